// File: rtl/sfd_pkg.sv
package sfd_pkg;

    // Frame layout
    localparam int unsigned FrameLen    = 25;
    localparam int unsigned HeldLen     = FrameLen - 1;
    localparam int unsigned NumChannels = 16;
    localparam int unsigned ChanBits    = 11;
    localparam int unsigned PayloadLen  = 22;
    localparam int unsigned PayloadBits = PayloadLen * 8;
    localparam int unsigned FlagPos     = 23;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE_0 = 8'h00;
    localparam logic [7:0] END_BYTE_1 = 8'h04;
    localparam logic [7:0] END_BYTE_2 = 8'h14;
    localparam logic [7:0] END_BYTE_3 = 8'h24;
    localparam logic [7:0] END_BYTE_4 = 8'h34;

    localparam logic [4:0] HELD_FULL = 5'(HeldLen);
    localparam logic [3:0] LAST_CHAN = 4'(NumChannels - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic shift_in;
        logic load;
        logic advance;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic frame_ok;
        logic last;
    } t_sts;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } t_state;

    function automatic logic end_byte_ok(input logic [7:0] b);
        return (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
               (b == END_BYTE_3) || (b == END_BYTE_4);
    endfunction

endpackage

// File: rtl/sfd_datapath.sv
module sfd_datapath import sfd_pkg::*; (
    input  logic                i_clk,
    input  logic [7:0]          i_rx_byte,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [3:0]          o_channel_index,
    output logic [10:0]         o_channel_value,
    output logic [7:0]          o_status_flags,
    output logic                o_last_channel
);

    // The last 24 bytes received; entry HeldLen-1 is the newest.
    logic [7:0]             r_win [HeldLen];
    logic [PayloadBits-1:0] r_payload;
    logic [PayloadBits-1:0] n_payload;
    logic [7:0]             r_flags;
    logic [3:0]             r_index;

    // Window shift line: every accepted item moves the bytes down by one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in) begin
            for (int i = 0; i < HeldLen - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[HeldLen-1] <= i_rx_byte;
        end
    end

    // The full frame is the held bytes plus the incoming one as the end byte.
    assign o_sts.frame_ok = (r_win[0] == START_BYTE) && end_byte_ok(i_rx_byte);
    assign o_sts.last     = (r_index == LAST_CHAN);

    // Payload register: loaded from frame bytes 1 to 22, then shifted one
    // channel at a time so the current channel always sits at the bottom.
    always_comb begin
        n_payload = r_payload;
        if (i_cmd.load) begin
            for (int j = 0; j < PayloadLen; j++) begin
                n_payload[j*8 +: 8] = r_win[j+1];
            end
        end else if (i_cmd.advance) begin
            n_payload = r_payload >> ChanBits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_payload <= n_payload;
        if (i_cmd.load) begin
            r_flags <= r_win[FlagPos];
        end
    end

    // Channel counter, restarted with each new frame.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_index <= '0;
        end else if (i_cmd.advance) begin
            r_index <= r_index + 4'd1;
        end
    end

    assign o_channel_index = r_index;
    assign o_channel_value = r_payload[ChanBits-1:0];
    assign o_status_flags  = r_flags;
    assign o_last_channel  = o_sts.last;

endmodule

// File: rtl/sfd_controller.sv
module sfd_controller import sfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rx_valid,
    output logic o_rx_ready,
    output logic o_res_valid,
    input  logic i_res_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [4:0] r_count;
    logic [4:0] n_count;
    logic       accept;
    logic       full;

    // Bytes are taken only while no frame is being emitted.
    assign o_rx_ready  = (r_state == ST_COLLECT);
    assign o_res_valid = (r_state == ST_EMIT);
    assign accept      = i_rx_valid && o_rx_ready;
    assign full        = accept && (r_count == HELD_FULL);

    assign o_cmd.shift_in = accept;
    assign o_cmd.load     = full && i_sts.frame_ok;
    assign o_cmd.advance  = o_res_valid && i_res_ready;

    // Byte count and state sequencing.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_COLLECT: begin
                if (full) begin
                    if (i_sts.frame_ok) begin
                        n_count = '0;
                        n_state = ST_EMIT;
                    end
                end else if (accept) begin
                    n_count = r_count + 5'd1;
                end
            end
            ST_EMIT: begin
                if (o_cmd.advance && i_sts.last) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HELD_FULL)
        else $error("byte count beyond held window");

    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_count == 5'd0))
        else $error("window not empty while emitting");

    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EMIT) && !o_rx_ready)
        else $error("good frame did not start emission");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.advance && i_sts.last) |=> (r_state == ST_COLLECT))
        else $error("emission did not end after last channel");
`endif

endmodule

// File: rtl/sbus_frame_decoder.sv
// Latency: a byte that completes a good frame gives the first result in the next cycle.
// Throughput: one byte per cycle while collecting; a good frame then emits its 16 channel
// items, one per cycle that the result side is ready, and bytes wait until the last one.
// The channel counter, stepping through the 16 channel items, ends the emission of one frame.
// Reset (synchronous, active low) clears the controller state and byte count; the window bytes are not reset.
module sbus_frame_decoder import sfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_channel_value,
    output logic [7:0]  o_status_flags,
    output logic        o_last_channel
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of collection and emission.
    sfd_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Window, frame check and channel unpacking.
    sfd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_status_flags  (o_status_flags),
        .o_last_channel  (o_last_channel)
    );

endmodule

// File: verif/tb_sbus_frame_decoder.sv
`timescale 1ns / 1ps

module tb_sbus_frame_decoder import sfd_pkg::*;;

    // One decoded channel as the result side should present it.
    typedef struct packed {
        logic [3:0]  index;
        logic [10:0] value;
        logic [7:0]  flags;
        logic        last;
    } t_chan_result;

    // How the payload bytes of a generated frame are filled.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [3:0]  chan_index;
    logic [10:0] chan_value;
    logic [7:0]  chan_flags;
    logic        chan_last;

    logic [7:0]   rx_bytes_pending[$];
    t_chan_result channels_due[$];
    t_chan_result oldest_due;

    // Own copy of the receive window.
    logic [7:0]   rx_window [FrameLen];
    int unsigned  bytes_held = 0;

    logic [7:0]   good_ends [5] = '{END_BYTE_0, END_BYTE_1, END_BYTE_2, END_BYTE_3, END_BYTE_4};
    int unsigned  end_turn = 0;
    int unsigned  bytes_queued = 0;

    int unsigned  sender_idle_pct = 24;
    int unsigned  recv_idle_pct = 55;
    logic         hold_go = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  error_count = 0;

    sbus_frame_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_channel_index (chan_index),
        .o_channel_value (chan_value),
        .o_status_flags  (chan_flags),
        .o_last_channel  (chan_last)
    );

    // Clock with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Takes in one received byte and queues the channels a completed good frame yields.
    function automatic void take_rx_byte(input logic [7:0] b);
        t_chan_result r;
        int unsigned  p;
        if (bytes_held >= FrameLen) begin
            bytes_held = 0;
        end
        rx_window[bytes_held] = b;
        bytes_held++;
        if (bytes_held < FrameLen) begin
            return;
        end
        // A bad start or end byte slides the window on by one byte.
        if (rx_window[0] != START_BYTE || !(rx_window[FrameLen - 1] inside
                {END_BYTE_0, END_BYTE_1, END_BYTE_2, END_BYTE_3, END_BYTE_4})) begin
            for (int j = 0; j < FrameLen - 1; j++) begin
                rx_window[j] = rx_window[j + 1];
            end
            bytes_held = FrameLen - 1;
            return;
        end
        // Channels are packed LSB first from the payload bytes.
        for (int k = 0; k < NumChannels; k++) begin
            r.index = 4'(k);
            r.flags = rx_window[FlagPos];
            r.last  = (k == NumChannels - 1);
            for (int bt = 0; bt < ChanBits; bt++) begin
                p = k * ChanBits + bt;
                r.value[bt] = rx_window[1 + p / 8][p % 8];
            end
            channels_due.push_back(r);
        end
        bytes_held = 0;
    endfunction

    function automatic logic [7:0] next_good_end();
        logic [7:0] e;
        e = good_ends[end_turn % 5];
        end_turn++;
        return e;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_frame(input logic [7:0] head, input t_fill fill,
                              input logic [7:0] flags, input logic [7:0] tail);
        push_byte(head);
        for (int j = 0; j < PayloadLen; j++) begin
            case (fill)
                FILL_ZERO: push_byte(8'h00);
                FILL_ONES: push_byte(8'hFF);
                default:   push_byte(8'($urandom_range(255)));
            endcase
        end
        push_byte(flags);
        push_byte(tail);
    endtask

    task automatic push_good_frame();
        int unsigned noise;
        noise = $urandom_range(3);
        repeat (noise) push_byte(8'($urandom_range(255)));
        if ($urandom_range(5) == 0) begin
            push_frame(START_BYTE, FILL_ZERO, 8'h00, next_good_end());
        end else begin
            push_frame(START_BYTE, FILL_RANDOM, 8'($urandom_range(255)), next_good_end());
        end
    endtask

    // Mix of good frames, broken frames and line noise, then one good frame.
    task automatic push_random_groups(input int unsigned budget);
        int unsigned start;
        logic [7:0]  b;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            case ($urandom_range(3))
                0: push_good_frame();
                1: begin
                    do b = 8'($urandom_range(255));
                    while (b inside {END_BYTE_0, END_BYTE_1, END_BYTE_2, END_BYTE_3, END_BYTE_4});
                    push_frame(START_BYTE, FILL_RANDOM, 8'($urandom_range(255)), b);
                end
                2: begin
                    do b = 8'($urandom_range(255));
                    while (b == START_BYTE);
                    push_frame(b, FILL_RANDOM, 8'($urandom_range(255)), next_good_end());
                end
                default: repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
            endcase
        end
        push_good_frame();
    endtask

    task automatic wait_drained();
        while (rx_bytes_pending.size() != 0 || rx_valid || channels_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Byte sender: holds each item until it is taken, idling at random between items.
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else begin
            if (rx_valid && rx_ready) begin
                take_rx_byte(rx_byte);
            end
            if (!rx_valid || rx_ready) begin
                if (rx_bytes_pending.size() != 0 &&
                        $urandom_range(99) >= sender_idle_pct) begin
                    rx_valid <= 1'b1;
                    rx_byte  <= rx_bytes_pending.pop_front();
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (hold_go) begin
                hold_left <= HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            res_ready <= !hold_go && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Result checker: each accepted item against the oldest expected channel.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            if (channels_due.size() == 0) begin
                report_mismatch($sformatf("channel %0d arrived with nothing due", chan_index));
            end else begin
                oldest_due = channels_due.pop_front();
                if (chan_index != oldest_due.index) begin
                    report_mismatch($sformatf("index %0d, want %0d", chan_index,
                                              oldest_due.index));
                end
                if (chan_value != oldest_due.value) begin
                    report_mismatch($sformatf("channel %0d value %h, want %h", oldest_due.index,
                                              chan_value, oldest_due.value));
                end
                if (chan_flags != oldest_due.flags) begin
                    report_mismatch($sformatf("channel %0d flags %h, want %h", oldest_due.index,
                                              chan_flags, oldest_due.flags));
                end
                if (chan_last != oldest_due.last) begin
                    report_mismatch($sformatf("channel %0d last %b, want %b", oldest_due.index,
                                              chan_last, oldest_due.last));
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge clk) begin
        if ((rx_valid && rx_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_sbus_frame_decoder: done, errors");
            $finish;
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes first: all payload bits set and every flag bit set.
        push_frame(START_BYTE, FILL_ONES, 8'hFF, next_good_end());
        push_good_frame();
        wait_drained();

        // Swapped idling; the receiver holds off while a frame and more bytes are offered.
        sender_idle_pct <= 55;
        recv_idle_pct   <= 24;
        hold_go         <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        push_frame(START_BYTE, FILL_RANDOM, 8'($urandom_range(255)), next_good_end());
        repeat (2) push_byte(8'($urandom_range(255)));
        wait_drained();

        // Full rate on both sides.
        sender_idle_pct <= 0;
        recv_idle_pct   <= 0;
        @(posedge clk);
        push_random_groups(10);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (channels_due.size() != 0) begin
            report_mismatch($sformatf("%0d channels never arrived", channels_due.size()));
        end
        if (error_count == 0) begin
            $display("tb_sbus_frame_decoder: done, clean");
        end else begin
            $display("tb_sbus_frame_decoder: done, errors");
        end
        $finish;
    end

endmodule
